// File: sv/mdts_pkg.sv
package mdts_pkg;

    localparam int NUM_STATES = 3;
    localparam int STATE_W    = 2;
    localparam int TIME_W     = 32;
    localparam int CODE_W     = 16;
    localparam int MEANS_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int TAU_W      = 20;
    localparam int FRAC_SHIFT = 12;

    localparam logic [TIME_W-1:0]  RST_WINDOW_LENGTH = 32'd25600;
    localparam logic [TIME_W-1:0]  RST_THRESHOLDS    = 32'hFFFF_FFFF;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH = 3'd0,
        REG_DWELL_MEANS   = 3'd1,
        REG_START_THR     = 3'd2,
        REG_ROW0_THR      = 3'd3,
        REG_ROW1_THR      = 3'd4,
        REG_ROW2_THR      = 3'd5
    } t_reg_idx;

    // First state whose cumulative threshold is at or above the draw;
    // the last state takes whatever is left.
    function automatic logic [STATE_W-1:0] choose_state(
        input logic [TIME_W-1:0] thr,
        input logic [CODE_W-1:0] u
    );
        logic [STATE_W-1:0] res;
        res = STATE_W'(NUM_STATES - 1);
        for (int s = NUM_STATES - 2; s >= 0; s--) begin
            if (u <= thr[CODE_W*s +: CODE_W]) begin
                res = STATE_W'(s);
            end
        end
        return res;
    endfunction

endpackage

// File: sv/mdts_in_if.sv
interface mdts_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [mdts_pkg::CODE_W-1:0]  exp_variate;
    logic [mdts_pkg::CODE_W-1:0]  uniform_draw;

    modport source (output valid, output op, output exp_variate, output uniform_draw,
                    input ready);
    modport sink   (input valid, input op, input exp_variate, input uniform_draw,
                    output ready);
endinterface

// File: sv/mdts_out_if.sv
interface mdts_out_if;
    logic                          valid;
    logic                          ready;
    logic [mdts_pkg::STATE_W-1:0]  current_state;
    logic                          window_done;
    logic                          step_ignored;
    logic [mdts_pkg::TIME_W-1:0]   total_state0;
    logic [mdts_pkg::TIME_W-1:0]   total_state1;
    logic [mdts_pkg::TIME_W-1:0]   total_state2;

    modport source (output valid, output current_state, output window_done,
                    output step_ignored, output total_state0, output total_state1,
                    output total_state2, input ready);
    modport sink   (input valid, input current_state, input window_done,
                    input step_ignored, input total_state0, input total_state1,
                    input total_state2, output ready);
endinterface

// File: sv/markov_dwell_time_simulator_core.sv
// Three-state Markov jump simulator driven by external random numbers. A start beat
// (op = 0) clears elapsed time and the per-state totals and picks the first state from
// the start thresholds; a step beat (op = 1) multiplies the Q4.12 exponential variate by
// the present state's Q8.8 mean dwell, clips the dwell at the window end, adds it to that
// state's total and jumps to the next state chosen by the uniform draw; a step beat with
// no window open is flagged as ignored. Every beat gives one result beat. The core takes
// one beat per cycle while the result side does not stall: a beat is registered on entry,
// then a 16x16 multiply, a 32-bit add and compare, and the state update feed the result register.
// Configuration registers may be written only while no beat is in flight.
module markov_dwell_time_simulator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mdts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mdts_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    mdts_in_if.sink                         i_in,
    mdts_out_if.source                      o_res
);
    import mdts_pkg::*;

    // configuration
    logic [TIME_W-1:0]  r_window_length;
    logic [MEANS_W-1:0] r_dwell_means;
    logic [TIME_W-1:0]  r_start_thr;
    logic [TIME_W-1:0]  r_row_thr [NUM_STATES];

    // simulator state
    logic [STATE_W-1:0] r_state,   n_state;
    logic [TIME_W-1:0]  r_elapsed, n_elapsed;
    logic [TIME_W-1:0]  r_tot [3];
    logic [TIME_W-1:0]  n_tot [3];
    logic               r_win_active, n_win_active;

    // input register
    logic               r_in_valid;
    logic               r_in_op;
    logic [CODE_W-1:0]  r_in_ev;
    logic [CODE_W-1:0]  r_in_u;

    // result register
    logic               r_out_valid;
    logic               r_out_done,    n_done;
    logic               r_out_ignored, n_ignored;

    logic advance;
    logic accept;

    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= RST_WINDOW_LENGTH;
            r_dwell_means   <= '0;
            r_start_thr     <= RST_THRESHOLDS;
            for (int i = 0; i < NUM_STATES; i++) begin
                r_row_thr[i] <= RST_THRESHOLDS;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_LENGTH: r_window_length <= i_cfg_wdata[TIME_W-1:0];
                REG_DWELL_MEANS:   r_dwell_means   <= i_cfg_wdata[MEANS_W-1:0];
                REG_START_THR:     r_start_thr     <= i_cfg_wdata[TIME_W-1:0];
                REG_ROW0_THR:      r_row_thr[0]    <= i_cfg_wdata[TIME_W-1:0];
                REG_ROW1_THR:      r_row_thr[1]    <= i_cfg_wdata[TIME_W-1:0];
                REG_ROW2_THR: begin
                    if (NUM_STATES > 2) begin
                        r_row_thr[NUM_STATES-1] <= i_cfg_wdata[TIME_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // dwell datapath
    logic [CODE_W-1:0]    mean;
    logic [2*CODE_W-1:0]  prod;
    logic [TAU_W-1:0]     tau_raw;
    logic [TIME_W-1:0]    remaining;
    logic [TIME_W-1:0]    tau;
    logic                 overrun;
    logic                 clip;
    logic [TIME_W-1:0]    row_thr;

    always_comb begin
        case (r_state)
            2'd0:    mean = r_dwell_means[0*CODE_W +: CODE_W];
            2'd1:    mean = r_dwell_means[1*CODE_W +: CODE_W];
            2'd2:    mean = r_dwell_means[2*CODE_W +: CODE_W];
            default: mean = '0;
        endcase
        row_thr = RST_THRESHOLDS;
        for (int i = 0; i < NUM_STATES; i++) begin
            if (r_state == STATE_W'(i)) begin
                row_thr = r_row_thr[i];
            end
        end
    end

    assign prod      = r_in_ev * mean;
    assign tau_raw   = prod[FRAC_SHIFT +: TAU_W];
    assign remaining = r_window_length - r_elapsed;
    assign overrun   = r_elapsed >= r_window_length;
    assign clip      = overrun || ({{(TIME_W-TAU_W){1'b0}}, tau_raw} >= remaining);
    assign tau       = overrun ? '0 :
                       clip    ? remaining : {{(TIME_W-TAU_W){1'b0}}, tau_raw};

    always_comb begin
        n_state      = r_state;
        n_elapsed    = r_elapsed;
        n_win_active = r_win_active;
        n_done       = 1'b0;
        n_ignored    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_tot[i] = r_tot[i];
        end
        if (r_in_op == OP_START) begin
            n_elapsed = '0;
            for (int i = 0; i < 3; i++) begin
                n_tot[i] = '0;
            end
            n_state      = choose_state(r_start_thr, r_in_u);
            n_win_active = (r_window_length != '0);
            n_done       = (r_window_length == '0);
        end else if (!r_win_active) begin
            n_ignored = 1'b1;
        end else begin
            n_elapsed = r_elapsed + tau;
            for (int i = 0; i < 3; i++) begin
                if (r_state == STATE_W'(i)) begin
                    n_tot[i] = r_tot[i] + tau;
                end
            end
            n_state = choose_state(row_thr, r_in_u);
            if (clip) begin
                n_done       = 1'b1;
                n_win_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '0;
            r_elapsed    <= '0;
            r_win_active <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_tot[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_state      <= n_state;
                r_elapsed    <= n_elapsed;
                r_win_active <= n_win_active;
                for (int i = 0; i < 3; i++) begin
                    r_tot[i] <= n_tot[i];
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_op <= i_in.op;
            r_in_ev <= i_in.exp_variate;
            r_in_u  <= i_in.uniform_draw;
        end
        if (advance) begin
            r_out_done    <= n_done;
            r_out_ignored <= n_ignored;
        end
    end

    // totals and state live in the state registers; the result beat shows them
    assign o_res.valid         = r_out_valid;
    assign o_res.current_state = r_state;
    assign o_res.window_done   = r_out_done;
    assign o_res.step_ignored  = r_out_ignored;
    assign o_res.total_state0  = r_tot[0];
    assign o_res.total_state1  = r_tot[1];
    assign o_res.total_state2  = r_tot[2];

`ifndef NO_ASSERTIONS
    a_done_xor_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_done && r_out_ignored))
        else $error("result flags both window_done and step_ignored");

    a_done_closes_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (!r_out_done || !r_win_active))
        else $error("window still active after a closing beat");

    a_ignored_keeps_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == OP_STEP && !r_win_active) |=>
            ($stable(r_tot[0]) && $stable(r_tot[1]) && $stable(r_tot[2])
             && $stable(r_state)))
        else $error("ignored step changed the simulator state");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state < STATE_W'(NUM_STATES))
        else $error("present state out of range");
`endif

endmodule

// File: test/markov_dwell_time_simulator_core_tb.sv
`timescale 1ns / 100ps

module markov_dwell_time_simulator_core_tb;
    import mdts_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 4;
    localparam logic [CFG_IDX_W-1:0] REG_PAST_LAST = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_CODE  = 3'd7;

    typedef struct {
        t_op               op;
        logic [CODE_W-1:0] ev;
        logic [CODE_W-1:0] u;
    } t_draw_item;

    typedef struct {
        logic [STATE_W-1:0] st;
        logic               done;
        logic               ignored;
        logic [TIME_W-1:0]  total [NUM_STATES];
    } t_dwell_report;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    mdts_in_if  stim_if ();
    mdts_out_if res_if ();

    markov_dwell_time_simulator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (stim_if),
        .o_res       (res_if)
    );

    // chain model: configuration copy and running state
    logic [TIME_W-1:0]  cfg_window;
    logic [MEANS_W-1:0] cfg_means;
    logic [TIME_W-1:0]  cfg_start_thr;
    logic [TIME_W-1:0]  cfg_row_thr [NUM_STATES];
    logic [STATE_W-1:0] chain_state;
    logic [TIME_W-1:0]  chain_elapsed;
    logic [TIME_W-1:0]  chain_total [NUM_STATES];
    logic               chain_active;

    t_draw_item    pending_draws [$];
    t_dwell_report expected_reports [$];
    t_draw_item    cur_draw;
    t_dwell_report want;

    int src_level, snk_level;
    int gap_left, stall_left, quiet_cycles;
    int n_beats_in, n_beats_out, n_closed, n_ignored, n_fail;

    always #5 i_clk = ~i_clk;

    function automatic logic [STATE_W-1:0] draw_to_state(logic [TIME_W-1:0] thr,
                                                         logic [CODE_W-1:0] u);
        if (u <= thr[15:0])
            return 2'd0;
        if (u <= thr[31:16])
            return 2'd1;
        return 2'd2;
    endfunction

    function automatic t_dwell_report advance_chain(t_draw_item it);
        t_dwell_report r;
        logic [STATE_W-1:0] st;
        logic [TIME_W-1:0]  dwell, room;
        r.done    = 1'b0;
        r.ignored = 1'b0;
        if (it.op == OP_START) begin
            chain_elapsed = '0;
            for (int s = 0; s < NUM_STATES; s++)
                chain_total[s] = '0;
            chain_state = draw_to_state(cfg_start_thr, it.u);
            chain_active = (cfg_window != 0);
            r.done = (cfg_window == 0);
        end else if (!chain_active) begin
            r.ignored = 1'b1;
        end else begin
            st    = chain_state;
            dwell = (32'(it.ev) * 32'(cfg_means[16*st +: 16])) >> FRAC_SHIFT;
            room  = cfg_window - chain_elapsed;
            if (chain_elapsed >= cfg_window || dwell >= room) begin
                // clip at the window end; if the window was shrunk under a running chain, nothing is left to add
                dwell = (chain_elapsed >= cfg_window) ? '0 : room;
                r.done = 1'b1;
                chain_active = 1'b0;
            end
            chain_elapsed  += dwell;
            chain_total[st] += dwell;
            chain_state = draw_to_state(cfg_row_thr[st], it.u);
        end
        r.st = chain_state;
        for (int s = 0; s < NUM_STATES; s++)
            r.total[s] = chain_total[s];
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int draw_gap(int level);
        int r;
        if (level == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CODE_W-1:0] pick_variate();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 16'h1FFF));
            default: return 16'($urandom);
        endcase
    endfunction

    // lands on and just past the threshold edges now and then
    function automatic logic [CODE_W-1:0] pick_uniform(logic [TIME_W-1:0] thr);
        case ($urandom_range(0, 9))
            0: return thr[15:0];
            1: return thr[15:0] + 16'd1;
            2: return thr[31:16];
            3: return thr[31:16] + 16'd1;
            4: return 16'h0000;
            5: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_draw(t_op op, logic [CODE_W-1:0] ev, logic [CODE_W-1:0] u);
        t_draw_item it;
        it.op = op;
        it.ev = ev;
        it.u  = u;
        pending_draws.push_back(it);
    endtask

    task automatic push_start();
        push_draw(OP_START, 16'($urandom), pick_uniform(cfg_start_thr));
    endtask

    task automatic push_step();
        push_draw(OP_STEP, pick_variate(), pick_uniform(cfg_row_thr[$urandom_range(0, 2)]));
    endtask

    // mostly whole windows (start then steps), with stray steps and restarts
    task automatic queue_windows(int n);
        int roll, k;
        while (pending_draws.size() < n) begin
            roll = $urandom_range(0, 9);
            if (roll < 8) begin
                push_start();
                k = $urandom_range(1, 24);
                repeat (k) push_step();
            end else if (roll < 9) begin
                repeat ($urandom_range(1, 4)) push_step();
            end else begin
                push_start();
            end
        end
    endtask

    // sampled mid-cycle so the clocked driver and checker have settled
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_draws.size() != 0 || stim_if.valid || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            REG_WINDOW_LENGTH: cfg_window     = data[31:0];
            REG_DWELL_MEANS:   cfg_means      = data[47:0];
            REG_START_THR:     cfg_start_thr  = data[31:0];
            REG_ROW0_THR:      cfg_row_thr[0] = data[31:0];
            REG_ROW1_THR:      cfg_row_thr[1] = data[31:0];
            REG_ROW2_THR:      cfg_row_thr[2] = data[31:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // upper bits of the 32-bit registers carry junk that must be dropped
    task automatic configure(logic [31:0] wl, logic [47:0] means, logic [31:0] start_thr,
                             logic [31:0] r0, logic [31:0] r1, logic [31:0] r2);
        write_reg(REG_WINDOW_LENGTH, {16'($urandom), wl});
        write_reg(REG_DWELL_MEANS, means);
        write_reg(REG_START_THR, {16'($urandom), start_thr});
        write_reg(REG_ROW0_THR, {16'($urandom), r0});
        write_reg(REG_ROW1_THR, {16'($urandom), r1});
        write_reg(REG_ROW2_THR, {16'($urandom), r2});
        end_writes();
    endtask

    function automatic logic [31:0] pick_thr_pair();
        logic [15:0] lo, hi, t;
        lo = 16'($urandom);
        hi = 16'($urandom);
        if ($urandom_range(0, 3) != 0 && lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        return {hi, lo};
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got);
        if (exp_v !== got) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got);
            n_fail++;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stim_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (stim_if.valid && stim_if.ready) begin
                expected_reports.push_back(advance_chain(cur_draw));
                n_beats_in++;
                gap_left = draw_gap(src_level);
            end
            if (stim_if.valid && !stim_if.ready) begin
                // hold the beat
            end else if (gap_left > 0) begin
                gap_left--;
                stim_if.valid <= 1'b0;
            end else if (pending_draws.size() != 0) begin
                cur_draw = pending_draws.pop_front();
                stim_if.valid        <= 1'b1;
                stim_if.op           <= cur_draw.op;
                stim_if.exp_variate  <= cur_draw.ev;
                stim_if.uniform_draw <= cur_draw.u;
            end else begin
                stim_if.valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                n_beats_out++;
                if (expected_reports.size() == 0) begin
                    $error("result beat with no beat pending");
                    n_fail++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("current_state", want.st, res_if.current_state);
                    check_field("window_done", want.done, res_if.window_done);
                    check_field("step_ignored", want.ignored, res_if.step_ignored);
                    check_field("total_state0", want.total[0], res_if.total_state0);
                    check_field("total_state1", want.total[1], res_if.total_state1);
                    check_field("total_state2", want.total[2], res_if.total_state2);
                    n_closed  += want.done;
                    n_ignored += want.ignored;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                stall_left = draw_gap(snk_level);
                if (stall_left > 0) begin
                    stall_left--;
                    res_if.ready <= 1'b0;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((stim_if.valid && stim_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Timeout: no beat moved for %0d cycles", WATCHDOG_CYCLES);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        stim_if.valid        = 1'b0;
        stim_if.op           = OP_START;
        stim_if.exp_variate  = '0;
        stim_if.uniform_draw = '0;
        res_if.ready = 1'b0;
        cfg_window    = RST_WINDOW_LENGTH;
        cfg_means     = '0;
        cfg_start_thr = RST_THRESHOLDS;
        for (int s = 0; s < NUM_STATES; s++) begin
            cfg_row_thr[s] = RST_THRESHOLDS;
            chain_total[s] = '0;
        end
        chain_state   = '0;
        chain_elapsed = '0;
        chain_active  = 1'b0;
        src_level = 1;
        snk_level = 1;
        quiet_cycles = 0;
        n_beats_in = 0;
        n_beats_out = 0;
        n_closed = 0;
        n_ignored = 0;
        n_fail = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: step before any window, then zero means never close it
        push_draw(OP_STEP, 16'hFFFF, 16'hFFFF);
        push_draw(OP_START, 16'h0000, 16'h0000);
        push_draw(OP_STEP, 16'hFFFF, 16'hFFFF);
        push_draw(OP_STEP, 16'h0000, 16'h0000);
        wait_drained();

        configure(32'h0000_0600, {16'h0040, 16'h0200, 16'h0100},
                  32'hC000_4000, 32'h8000_2000, 32'hF000_1000, 32'hFFFF_0000);
        push_draw(OP_START, 16'h1234, 16'h4000);
        push_draw(OP_START, 16'h4321, 16'h4001);
        push_draw(OP_START, 16'hAAAA, 16'hC000);
        push_draw(OP_START, 16'h5555, 16'hC001);
        push_draw(OP_START, 16'h0000, 16'h0000);
        push_draw(OP_STEP, 16'h0000, 16'h2000);
        push_draw(OP_STEP, 16'h1000, 16'h2001);
        push_draw(OP_STEP, 16'h0800, 16'h0000);
        push_draw(OP_STEP, 16'hFFFF, 16'hFFFF);
        push_draw(OP_STEP, 16'h1000, 16'h1000);
        push_draw(OP_START, 16'hFFFF, 16'hFFFF);
        push_draw(OP_STEP, 16'h2000, 16'h8001);
        wait_drained();

        // zero-length window closes on the start itself
        configure(32'h0000_0000, '1, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0000_0000);
        write_reg(REG_PAST_LAST, '1);
        write_reg(REG_TOP_CODE, '0);
        end_writes();
        push_draw(OP_START, 16'hFFFF, 16'h0000);
        push_draw(OP_STEP, 16'hFFFF, 16'h0001);
        push_draw(OP_START, 16'h0000, 16'hFFFF);
        wait_drained();

        // widest window and largest means: totals grow large
        src_level = 0;
        snk_level = 0;
        configure(32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, 32'h5555_1111,
                  32'hEEEE_7777, 32'hFFFF_FFFF);
        push_start();
        repeat (60) push_step();
        queue_windows(100);
        push_draw(OP_START, 16'h0000, 16'h0000);
        push_draw(OP_STEP, 16'hFFFF, 16'h0000);
        wait_drained();

        // shrink the window under a running chain
        src_level = 1;
        snk_level = 1;
        write_reg(REG_WINDOW_LENGTH, 48'h0000_0000_0001);
        end_writes();
        push_draw(OP_STEP, 16'h8000, 16'h9000);
        push_draw(OP_STEP, 16'h8000, 16'h9000);
        queue_windows(30);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            src_level = (ph % 3 == 2) ? 0 : 1;
            snk_level = (ph % 4 == 1) ? 0 : 1;
            configure(($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 255))
                                                  : 32'($urandom_range(256, 51200)),
                      {16'($urandom_range(16, 1024)), 16'($urandom_range(16, 1024)),
                       16'($urandom_range(16, 1024))},
                      pick_thr_pair(), pick_thr_pair(), pick_thr_pair(), pick_thr_pair());
            if (ph == 5) begin
                // sender waits for every result mid-phase, then resumes
                queue_windows(60);
                wait_drained();
                queue_windows(60);
            end else begin
                queue_windows(120);
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("Covered %0d input beats and %0d result beats over 13 register settings;",
                 n_beats_in, n_beats_out);
        $display("%0d windows closed, %0d steps arrived with no window open.",
                 n_closed, n_ignored);
        if (n_fail == 0 && expected_reports.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            if (expected_reports.size() != 0)
                $error("%0d results never arrived", expected_reports.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
